[rtl/esm_pkg.sv]
// shared constants, types and codes of the event sequence matcher bank
package esm_pkg;

  localparam int NUM_MATCHERS = 32;
  localparam int MAX_SEQ_LEN  = 4;
  localparam int CODE_WIDTH   = 8;

  // fixed port field widths
  localparam int OP_W      = 2;
  localparam int EVCODE_W  = 8;
  localparam int TIME_W    = 32;
  localparam int MIDX_W    = 5;
  localparam int CPOS_W    = 2;
  localparam int SLEN_W    = 3;
  localparam int ACT_W     = 8;

  // derived internal widths
  localparam int IDX_W     = (NUM_MATCHERS > 1) ? $clog2(NUM_MATCHERS) : 1;
  localparam int CNT_W     = $clog2(NUM_MATCHERS + 1);
  localparam int POS_W     = (MAX_SEQ_LEN > 1) ? $clog2(MAX_SEQ_LEN) : 1;
  localparam int LEN_W     = $clog2(MAX_SEQ_LEN + 1);
  localparam int PAT_DEPTH = NUM_MATCHERS * MAX_SEQ_LEN;
  localparam int PAT_AW    = (PAT_DEPTH > 1) ? $clog2(PAT_DEPTH) : 1;

  typedef enum logic [OP_W-1:0] {
    OP_EVENT   = 2'd0,
    OP_PATTERN = 2'd1,
    OP_DESC    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic              strict;
    logic [ACT_W-1:0]  action;
    logic [POS_W-1:0]  progress;
  } desc_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    desc_t             data;
  } desc_wr_t;

  typedef struct packed {
    logic                  en;
    logic [PAT_AW-1:0]     addr;
    logic [CODE_WIDTH-1:0] code;
  } pat_wr_t;

  // address of one pattern code in the flat pattern memory
  function automatic logic [PAT_AW-1:0] pat_addr(input logic [IDX_W-1:0] m,
                                                 input logic [POS_W-1:0] p);
    logic [31:0] a;
    a = 32'(m) * 32'(MAX_SEQ_LEN) + 32'(p);
    return a[PAT_AW-1:0];
  endfunction

endpackage

[rtl/esm_tables.sv]
// descriptor and pattern memories with per-matcher valid bits
module esm_tables (
  input  logic                           clk,
  input  logic                           rst_n,
  input  esm_pkg::desc_wr_t              desc_wr,
  input  logic                           desc_rd_en,
  input  logic [esm_pkg::IDX_W-1:0]      desc_rd_addr,
  output esm_pkg::desc_t                 desc_rd,
  input  esm_pkg::pat_wr_t               pat_wr,
  input  logic                           pat_rd_en,
  input  logic [esm_pkg::PAT_AW-1:0]     pat_rd_addr,
  output logic [esm_pkg::CODE_WIDTH-1:0] pat_rd
);

  esm_pkg::desc_t                 desc_mem [esm_pkg::NUM_MATCHERS];
  logic [esm_pkg::CODE_WIDTH-1:0] pat_mem  [esm_pkg::PAT_DEPTH];
  logic [esm_pkg::NUM_MATCHERS-1:0] desc_vld_r;
  esm_pkg::desc_t                 desc_q_r;
  logic                           desc_q_vld_r;
  logic [esm_pkg::CODE_WIDTH-1:0] pat_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_vld_r <= '0;
    end else if (desc_wr.en) begin
      desc_vld_r[desc_wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (desc_wr.en) begin
      desc_mem[desc_wr.addr] <= desc_wr.data;
    end
    if (desc_rd_en) begin
      desc_q_r     <= desc_mem[desc_rd_addr];
      desc_q_vld_r <= desc_vld_r[desc_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pat_wr.en) begin
      pat_mem[pat_wr.addr] <= pat_wr.code;
    end
    if (pat_rd_en) begin
      pat_q_r <= pat_mem[pat_rd_addr];
    end
  end

  // a never-written descriptor reads as a disabled matcher at start
  always_comb begin
    desc_rd = desc_q_r;
    if (!desc_q_vld_r) begin
      desc_rd.len      = '0;
      desc_rd.progress = '0;
    end
  end

  assign pat_rd = pat_q_r;

endmodule

[rtl/event_sequence_matcher_bank.sv]
// top level of the event sequence matcher bank: scan pipeline and result staging
//
//  channel  | handshake                         | word
//  ---------+-----------------------------------+---------------------------------------
//  input    | start, busy (taken: start & !busy)| in_op .. in_action_code
//  result   | out_valid, one cycle, no stall    | out_action .. out_last_of_run
//  config   | cfg_valid, cfg_ready              | cfg_timer_wrap_at
//
// load ops never raise busy.
// an event raises busy while its scan runs: one descriptor read per cycle
// feeds a three-stage read / pattern read / compare-and-write-back pipeline.
// each result is held one step so the final one of an event carries last_of_run.
// reset clears the valid bits of the descriptor memory, so no clearing pass is needed.
module event_sequence_matcher_bank (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [esm_pkg::OP_W-1:0]       in_op,
  input  logic [esm_pkg::EVCODE_W-1:0]   in_event_code,
  input  logic [esm_pkg::TIME_W-1:0]     in_event_time,
  input  logic [esm_pkg::MIDX_W-1:0]     in_matcher_index,
  input  logic [esm_pkg::CPOS_W-1:0]     in_code_position,
  input  logic [esm_pkg::SLEN_W-1:0]     in_sequence_length,
  input  logic                           in_strict_order,
  input  logic [esm_pkg::ACT_W-1:0]      in_action_code,
  output logic                           out_valid,
  output logic [esm_pkg::ACT_W-1:0]      out_action,
  output logic [esm_pkg::TIME_W-1:0]     out_action_time,
  output logic [esm_pkg::TIME_W-1:0]     out_time_since_last,
  output logic                           out_last_of_run,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [esm_pkg::TIME_W-1:0]     cfg_timer_wrap_at
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t                         state_r;
  logic [esm_pkg::CNT_W-1:0]      cnt_r;
  logic [esm_pkg::TIME_W-1:0]     wrap_r;
  logic [esm_pkg::TIME_W-1:0]     last_r;
  logic [esm_pkg::TIME_W-1:0]     now_r;
  logic [esm_pkg::CODE_WIDTH-1:0] code_r;

  logic                           s1_vld_r;
  logic [esm_pkg::IDX_W-1:0]      s1_m_r;
  logic                           s2_vld_r;
  logic [esm_pkg::IDX_W-1:0]      s2_m_r;
  esm_pkg::desc_t                 s2_desc_r;

  logic                           pend_vld_r;
  logic [esm_pkg::ACT_W-1:0]      pend_act_r;
  logic [esm_pkg::TIME_W-1:0]     pend_time_r;
  logic [esm_pkg::TIME_W-1:0]     pend_diff_r;

  logic                           out_valid_r;
  logic [esm_pkg::ACT_W-1:0]      out_action_r;
  logic [esm_pkg::TIME_W-1:0]     out_time_r;
  logic [esm_pkg::TIME_W-1:0]     out_diff_r;
  logic                           out_last_r;

  esm_pkg::desc_wr_t              desc_wr;
  esm_pkg::pat_wr_t               pat_wr;
  esm_pkg::desc_t                 desc_rd;
  logic [esm_pkg::CODE_WIDTH-1:0] pat_rd;
  logic                           desc_rd_en;
  logic                           pat_rd_en;
  logic [esm_pkg::PAT_AW-1:0]     pat_rd_addr;

  logic                           accept;
  esm_pkg::op_t                   op;
  logic [31:0]                    idx_ext;
  logic [31:0]                    code_ext;
  logic                           idx_ok;
  logic                           pos_ok;
  logic [esm_pkg::LEN_W-1:0]      len_sat;
  logic                           scan_done;
  logic [esm_pkg::POS_W-1:0]      s1_p;
  logic                           hit;
  logic [esm_pkg::LEN_W-1:0]      p_inc;
  logic                           complete;
  logic [esm_pkg::POS_W-1:0]      p_new;
  logic [esm_pkg::TIME_W-1:0]     elapsed;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign op        = esm_pkg::op_t'(in_op);
  assign idx_ext   = 32'(in_matcher_index);
  assign code_ext  = 32'(in_event_code);
  assign idx_ok    = idx_ext < 32'(esm_pkg::NUM_MATCHERS);
  assign pos_ok    = 32'(in_code_position) < 32'(esm_pkg::MAX_SEQ_LEN);

  always_comb begin
    if (32'(in_sequence_length) > 32'(esm_pkg::MAX_SEQ_LEN)) begin
      len_sat = esm_pkg::LEN_W'(esm_pkg::MAX_SEQ_LEN);
    end else begin
      len_sat = esm_pkg::LEN_W'(in_sequence_length);
    end
  end

  // stage 0: descriptor read for matcher cnt_r
  assign desc_rd_en = (state_r == S_SCAN) && (cnt_r != esm_pkg::CNT_W'(esm_pkg::NUM_MATCHERS));
  assign scan_done  = (state_r == S_SCAN) && !desc_rd_en && !s1_vld_r && !s2_vld_r;

  // stage 1: clip progress, read the expected code
  always_comb begin
    if (esm_pkg::LEN_W'(desc_rd.progress) >= desc_rd.len) begin
      s1_p = '0;
    end else begin
      s1_p = desc_rd.progress;
    end
  end
  assign pat_rd_en   = s1_vld_r;
  assign pat_rd_addr = esm_pkg::pat_addr(s1_m_r, s1_p);

  // stage 2: compare, advance and write back
  assign hit      = (pat_rd == code_r);
  assign p_inc    = esm_pkg::LEN_W'(s2_desc_r.progress) + 1'b1;
  assign complete = s2_vld_r && hit && (p_inc >= s2_desc_r.len);

  always_comb begin
    if (hit) begin
      p_new = complete ? '0 : esm_pkg::POS_W'(p_inc);
    end else if (s2_desc_r.strict) begin
      p_new = '0;
    end else begin
      p_new = s2_desc_r.progress;
    end
  end

  always_comb begin
    if (last_r <= now_r) begin
      elapsed = now_r - last_r;
    end else begin
      elapsed = wrap_r - last_r + 32'd1 + now_r;
    end
  end

  // one write port shared by descriptor loads and scan write-back
  always_comb begin
    desc_wr = '0;
    if (s2_vld_r) begin
      desc_wr.en            = 1'b1;
      desc_wr.addr          = s2_m_r;
      desc_wr.data          = s2_desc_r;
      desc_wr.data.progress = p_new;
    end else if (accept && op == esm_pkg::OP_DESC && idx_ok) begin
      desc_wr.en            = 1'b1;
      desc_wr.addr          = idx_ext[esm_pkg::IDX_W-1:0];
      desc_wr.data.len      = len_sat;
      desc_wr.data.strict   = in_strict_order;
      desc_wr.data.action   = in_action_code;
      desc_wr.data.progress = '0;
    end
  end

  always_comb begin
    pat_wr      = '0;
    pat_wr.en   = accept && op == esm_pkg::OP_PATTERN && idx_ok && pos_ok;
    pat_wr.addr = esm_pkg::pat_addr(idx_ext[esm_pkg::IDX_W-1:0],
                                    esm_pkg::POS_W'(in_code_position));
    pat_wr.code = code_ext[esm_pkg::CODE_WIDTH-1:0];
  end

  esm_tables u_tables (
    .clk          (clk),
    .rst_n        (rst_n),
    .desc_wr      (desc_wr),
    .desc_rd_en   (desc_rd_en),
    .desc_rd_addr (cnt_r[esm_pkg::IDX_W-1:0]),
    .desc_rd      (desc_rd),
    .pat_wr       (pat_wr),
    .pat_rd_en    (pat_rd_en),
    .pat_rd_addr  (pat_rd_addr),
    .pat_rd       (pat_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      wrap_r      <= '1;
      last_r      <= '0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        wrap_r <= cfg_timer_wrap_at;
      end
      s1_vld_r <= desc_rd_en;
      s2_vld_r <= s1_vld_r && (desc_rd.len != '0);
      // a held result goes out when the next one arrives or the scan ends
      out_valid_r <= (complete || scan_done) && pend_vld_r;
      if (desc_rd_en) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (complete) begin
        last_r     <= now_r;
        pend_vld_r <= 1'b1;
      end
      case (state_r)
        S_IDLE: begin
          if (accept && op == esm_pkg::OP_EVENT) begin
            state_r <= S_SCAN;
            cnt_r   <= '0;
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            state_r    <= S_IDLE;
            pend_vld_r <= 1'b0;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept && op == esm_pkg::OP_EVENT) begin
      now_r  <= in_event_time;
      code_r <= code_ext[esm_pkg::CODE_WIDTH-1:0];
    end
    if (s1_vld_r) begin
      s2_m_r    <= s1_m_r;
      s2_desc_r <= '{len: desc_rd.len, strict: desc_rd.strict, action: desc_rd.action,
                     progress: s1_p};
    end
    if (desc_rd_en) begin
      s1_m_r <= cnt_r[esm_pkg::IDX_W-1:0];
    end
    if (complete) begin
      pend_act_r  <= s2_desc_r.action;
      pend_time_r <= now_r;
      pend_diff_r <= elapsed;
    end
    if ((complete || scan_done) && pend_vld_r) begin
      out_action_r <= pend_act_r;
      out_time_r   <= pend_time_r;
      out_diff_r   <= pend_diff_r;
      // a later completion means the held word is not the last of the event
      out_last_r   <= scan_done;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_action          = out_action_r;
  assign out_action_time     = out_time_r;
  assign out_time_since_last = out_diff_r;
  assign out_last_of_run     = out_last_r;

`ifndef SYNTHESIS
  a_out_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_SCAN))
    else $error("result word outside an event scan");

  a_last_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_run |-> !busy)
    else $error("final word of an event while still scanning");

  a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r || s2_vld_r |-> state_r == S_SCAN)
    else $error("scan pipeline active while idle");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_vld_r)
    else $error("held result left behind after scan");

  a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r |-> !(desc_rd_en && desc_wr.addr == cnt_r[esm_pkg::IDX_W-1:0]))
    else $error("descriptor read and write-back hit the same entry");
`endif

endmodule

[tb/sv/tb.sv]
// self-checking testbench for the event sequence matcher bank: directed table, then random words
module tb;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = esm_pkg::NUM_MATCHERS + 8;
  localparam int PHASE_WORDS  = 41;

  typedef struct {
    esm_pkg::op_t op;
    logic [7:0]   code;
    logic [31:0]  stamp;
    logic [4:0]   idx;
    logic [1:0]   pos;
    logic [2:0]   len;
    logic         strict;
    logic [7:0]   act;
  } cmd_t;

  typedef struct {
    logic [7:0]  action;
    logic [31:0] at;
    logic [31:0] since;
    logic        last;
  } action_rec_t;

  typedef struct {
    cmd_t        c;
    bit          typed;
    int          n_exp;
    logic [7:0]  e_act;
    logic [31:0] e_at;
    logic [31:0] e_since;
  } table_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_op;
  logic [7:0]  in_event_code;
  logic [31:0] in_event_time;
  logic [4:0]  in_matcher_index;
  logic [1:0]  in_code_position;
  logic [2:0]  in_sequence_length;
  logic        in_strict_order;
  logic [7:0]  in_action_code;
  logic        out_valid;
  logic [7:0]  out_action;
  logic [31:0] out_action_time;
  logic [31:0] out_time_since_last;
  logic        out_last_of_run;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_timer_wrap_at;

  // predictor copy of the bank
  logic [esm_pkg::CODE_WIDTH-1:0] pat_mem [esm_pkg::PAT_DEPTH];
  bit          pat_set [esm_pkg::PAT_DEPTH] = '{default: 1'b0};
  int          m_len [esm_pkg::NUM_MATCHERS] = '{default: 0};
  int          m_prog [esm_pkg::NUM_MATCHERS] = '{default: 0};
  bit          m_strict [esm_pkg::NUM_MATCHERS];
  logic [7:0]  m_act [esm_pkg::NUM_MATCHERS];
  logic [31:0] last_done = 32'd0;
  logic [31:0] wrap_at = 32'hFFFF_FFFF;

  action_rec_t step_actions [$];
  action_rec_t table_exp [$];
  action_rec_t actions_due [$];
  action_rec_t due;
  table_row_t  dir_table [$];
  logic [31:0] wrap_plan [5];

  longint ev_clock = 0;
  bit     no_gaps = 1'b0;
  int     words_sent = 0;
  int     results_seen = 0;
  int     mismatches = 0;
  int     idle_cycles = 0;

  event_sequence_matcher_bank dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_op              (in_op),
    .in_event_code      (in_event_code),
    .in_event_time      (in_event_time),
    .in_matcher_index   (in_matcher_index),
    .in_code_position   (in_code_position),
    .in_sequence_length (in_sequence_length),
    .in_strict_order    (in_strict_order),
    .in_action_code     (in_action_code),
    .out_valid          (out_valid),
    .out_action         (out_action),
    .out_action_time    (out_action_time),
    .out_time_since_last(out_time_since_last),
    .out_last_of_run    (out_last_of_run),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_timer_wrap_at  (cfg_timer_wrap_at)
  );

  always #5 clk = ~clk;

  // apply one word to the predictor copy of the bank and collect the actions it completes
  function automatic void predict_actions(cmd_t c);
    int n;
    int p;
    int a;
    action_rec_t rec;
    step_actions.delete();
    case (c.op)
      esm_pkg::OP_PATTERN: begin
        a = int'(c.idx) * esm_pkg::MAX_SEQ_LEN + int'(c.pos);
        pat_mem[a] = c.code[esm_pkg::CODE_WIDTH-1:0];
        pat_set[a] = 1'b1;
      end
      esm_pkg::OP_DESC: begin
        n = int'(c.len);
        m_len[c.idx] = (n > esm_pkg::MAX_SEQ_LEN) ? esm_pkg::MAX_SEQ_LEN : n;
        m_strict[c.idx] = c.strict;
        m_act[c.idx] = c.act;
        m_prog[c.idx] = 0;
      end
      esm_pkg::OP_EVENT: begin
        for (int m = 0; m < esm_pkg::NUM_MATCHERS; m++) begin
          n = m_len[m];
          p = m_prog[m];
          if (n == 0) continue;
          if (p >= n) p = 0;
          if (pat_mem[m * esm_pkg::MAX_SEQ_LEN + p] == c.code[esm_pkg::CODE_WIDTH-1:0]) begin
            p++;
            if (p >= n) begin
              rec.action = m_act[m];
              rec.at = c.stamp;
              // elapsed time, folded through the wrap point when the timer rolled over
              rec.since = (last_done <= c.stamp) ? c.stamp - last_done
                                                 : wrap_at - last_done + 32'd1 + c.stamp;
              rec.last = 1'b0;
              last_done = c.stamp;
              step_actions.push_back(rec);
              p = 0;
            end
          end else if (m_strict[m]) begin
            p = 0;
          end
          m_prog[m] = p;
        end
      end
      default: ;
    endcase
    if (step_actions.size() > 0) step_actions[step_actions.size() - 1].last = 1'b1;
  endfunction

  function automatic cmd_t rand_word();
    cmd_t c;
    c.op = esm_pkg::op_t'($urandom_range(0, 3));
    c.code = 8'($urandom_range(0, 255));
    c.stamp = $urandom;
    c.idx = 5'($urandom_range(0, 31));
    c.pos = 2'($urandom_range(0, 3));
    c.len = 3'($urandom_range(0, 7));
    c.strict = 1'($urandom_range(0, 1));
    c.act = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic cmd_t ev(logic [7:0] code, logic [31:0] stamp);
    cmd_t c;
    c = rand_word();
    c.op = esm_pkg::OP_EVENT;
    c.code = code;
    c.stamp = stamp;
    return c;
  endfunction

  function automatic cmd_t pat(logic [4:0] idx, logic [1:0] pos, logic [7:0] code);
    cmd_t c;
    c = rand_word();
    c.op = esm_pkg::OP_PATTERN;
    c.idx = idx;
    c.pos = pos;
    c.code = code;
    return c;
  endfunction

  function automatic cmd_t desc(logic [4:0] idx, logic [2:0] len, logic strict, logic [7:0] act);
    cmd_t c;
    c = rand_word();
    c.op = esm_pkg::OP_DESC;
    c.idx = idx;
    c.len = len;
    c.strict = strict;
    c.act = act;
    return c;
  endfunction

  function automatic void put(cmd_t c, bit typed, int n, logic [7:0] a, logic [31:0] t,
                              logic [31:0] s);
    table_row_t r;
    r.c = c;
    r.typed = typed;
    r.n_exp = n;
    r.e_act = a;
    r.e_at = t;
    r.e_since = s;
    dir_table.push_back(r);
  endfunction

  // a few codes shared by patterns and events so that matches are common
  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 4))
      0: return 8'h00;
      1: return 8'h3C;
      2: return 8'hC3;
      3: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [31:0] next_stamp();
    if ($urandom_range(0, 7) == 0) return $urandom;
    ev_clock += $urandom_range(0, 60);
    if (ev_clock > longint'(wrap_at)) ev_clock = ev_clock % (longint'(wrap_at) + 1);
    return ev_clock[31:0];
  endfunction

  task automatic note_mismatch(string what);
    mismatches++;
    $display("MISMATCH @%0t: %s", $time, what);
  endtask

  // called at a falling edge, returns at the falling edge after the word was taken
  task automatic send_word(cmd_t c, bit from_table);
    int gap;
    if ($urandom_range(0, 15) == 0) no_gaps = !no_gaps;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_op = c.op;
    in_event_code = c.code;
    in_event_time = c.stamp;
    in_matcher_index = c.idx;
    in_code_position = c.pos;
    in_sequence_length = c.len;
    in_strict_order = c.strict;
    in_action_code = c.act;
    start = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    predict_actions(c);
    if (from_table) begin
      foreach (table_exp[i]) actions_due.push_back(table_exp[i]);
    end else begin
      foreach (step_actions[i]) actions_due.push_back(step_actions[i]);
    end
    if (c.op != esm_pkg::OP_NONE) words_sent++;
    @(negedge clk);
  endtask

  task automatic set_wrap(logic [31:0] value);
    start = 1'b0;
    while (actions_due.size() != 0) @(negedge clk);
    // an event that completes nothing may still be scanning
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_timer_wrap_at = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    wrap_at = value;
    @(negedge clk);
    cfg_valid = 1'b0;
    ev_clock = (value > 3000) ? longint'(value) - $urandom_range(0, 3000) : 0;
  endtask

  task automatic random_item();
    int r;
    int m;
    int n;
    int live [$];
    cmd_t c;
    r = $urandom_range(0, 99);
    for (m = 0; m < esm_pkg::NUM_MATCHERS; m++) if (m_len[m] > 0) live.push_back(m);
    if (r < 50 && live.size() > 0) begin
      // feed the code some enabled matcher is waiting for
      m = live[$urandom_range(0, live.size() - 1)];
      send_word(ev(pat_mem[m * esm_pkg::MAX_SEQ_LEN + m_prog[m]], next_stamp()), 1'b0);
    end else if (r < 68) begin
      send_word(ev(pick_code(), next_stamp()), 1'b0);
    end else if (r < 82) begin
      c = desc(5'($urandom_range(0, esm_pkg::NUM_MATCHERS - 1)), 3'($urandom_range(0, 7)),
               1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      n = (int'(c.len) > esm_pkg::MAX_SEQ_LEN) ? esm_pkg::MAX_SEQ_LEN : int'(c.len);
      // every position the matcher can read gets a code first
      for (int p = 0; p < n; p++) begin
        if (!pat_set[int'(c.idx) * esm_pkg::MAX_SEQ_LEN + p])
          send_word(pat(c.idx, 2'(p), pick_code()), 1'b0);
      end
      send_word(c, 1'b0);
    end else if (r < 96) begin
      send_word(pat(5'($urandom_range(0, esm_pkg::NUM_MATCHERS - 1)), 2'($urandom_range(0, 3)),
                    pick_code()), 1'b0);
    end else begin
      c = rand_word();
      c.op = esm_pkg::OP_NONE;
      send_word(c, 1'b0);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      results_seen++;
      if (actions_due.size() == 0) begin
        note_mismatch($sformatf("action %h with nothing pending", out_action));
      end else begin
        due = actions_due.pop_front();
        if (out_action !== due.action)
          note_mismatch($sformatf("#%0d action %h, want %h", results_seen, out_action,
                                  due.action));
        if (out_action_time !== due.at)
          note_mismatch($sformatf("#%0d action_time %h, want %h", results_seen,
                                  out_action_time, due.at));
        if (out_time_since_last !== due.since)
          note_mismatch($sformatf("#%0d time_since_last %h, want %h", results_seen,
                                  out_time_since_last, due.since));
        if (out_last_of_run !== due.last)
          note_mismatch($sformatf("#%0d last_of_run %b, want %b", results_seen,
                                  out_last_of_run, due.last));
      end
    end
  end

  // counts cycles in which no word moves on any channel
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1 ||
        (cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    cmd_t        c;
    int          base;
    action_rec_t rec;
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_op = esm_pkg::OP_EVENT;
    in_event_code = '0;
    in_event_time = '0;
    in_matcher_index = '0;
    in_code_position = '0;
    in_sequence_length = '0;
    in_strict_order = 1'b0;
    in_action_code = '0;
    cfg_valid = 1'b0;
    cfg_timer_wrap_at = '0;
    wrap_plan = '{32'd0, 32'd4999, 32'hFFFF_FFFF, 32'h8000_0000, 32'd0};
    wrap_plan[4] = $urandom;

    // after reset every matcher is disabled; op 3 is ignored
    put(ev(8'h00, 32'd0), 1, 0, 8'h00, 32'd0, 32'd0);
    c = rand_word();
    c.op = esm_pkg::OP_NONE;
    c.code = 8'hFF;
    c.stamp = 32'hFFFF_FFFF;
    c.idx = 5'd31;
    c.pos = 2'd3;
    c.len = 3'd7;
    c.strict = 1'b1;
    c.act = 8'hFF;
    put(c, 1, 0, 8'h00, 32'd0, 32'd0);
    // single-code strict matcher, then a completion that crosses the wrap
    put(pat(5'd0, 2'd0, 8'hFF), 1, 0, 8'h00, 32'd0, 32'd0);
    put(desc(5'd0, 3'd1, 1'b1, 8'hA5), 1, 0, 8'h00, 32'd0, 32'd0);
    put(ev(8'hFF, 32'd100), 1, 1, 8'hA5, 32'd100, 32'd100);
    put(ev(8'hFF, 32'd50), 1, 1, 8'hA5, 32'd50, 32'hFFFF_FFCE);
    // relaxed four-code matcher at the top index, overlong length saturates
    put(pat(5'd31, 2'd0, 8'h00), 1, 0, 8'h00, 32'd0, 32'd0);
    put(pat(5'd31, 2'd1, 8'h55), 1, 0, 8'h00, 32'd0, 32'd0);
    put(pat(5'd31, 2'd2, 8'hAA), 1, 0, 8'h00, 32'd0, 32'd0);
    put(pat(5'd31, 2'd3, 8'h00), 1, 0, 8'h00, 32'd0, 32'd0);
    put(desc(5'd31, 3'd7, 1'b0, 8'h00), 1, 0, 8'h00, 32'd0, 32'd0);
    put(ev(8'h00, 32'hFFFF_FFFF), 1, 0, 8'h00, 32'd0, 32'd0);
    put(ev(8'h33, 32'hFFFF_FFFF), 1, 0, 8'h00, 32'd0, 32'd0);
    put(ev(8'h55, 32'd200), 0, 0, 8'h00, 32'd0, 32'd0);
    put(ev(8'hAA, 32'd300), 0, 0, 8'h00, 32'd0, 32'd0);
    put(ev(8'h00, 32'hFFFF_FFFF), 1, 1, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFCD);
    // two matchers complete on one event
    put(pat(5'd1, 2'd0, 8'hFF), 0, 0, 8'h00, 32'd0, 32'd0);
    put(desc(5'd1, 3'd1, 1'b0, 8'h5A), 0, 0, 8'h00, 32'd0, 32'd0);
    put(ev(8'hFF, 32'd0), 0, 0, 8'h00, 32'd0, 32'd0);
    // strict restart must not retest the code that broke the sequence
    put(pat(5'd2, 2'd0, 8'h11), 0, 0, 8'h00, 32'd0, 32'd0);
    put(pat(5'd2, 2'd1, 8'h22), 0, 0, 8'h00, 32'd0, 32'd0);
    put(desc(5'd2, 3'd2, 1'b1, 8'hC3), 0, 0, 8'h00, 32'd0, 32'd0);
    put(ev(8'h11, 32'd10), 0, 0, 8'h00, 32'd0, 32'd0);
    put(ev(8'h11, 32'd20), 0, 0, 8'h00, 32'd0, 32'd0);
    put(ev(8'h22, 32'd30), 0, 0, 8'h00, 32'd0, 32'd0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_table[i]) begin
      table_exp.delete();
      if (dir_table[i].typed && dir_table[i].n_exp > 0) begin
        rec.action = dir_table[i].e_act;
        rec.at = dir_table[i].e_at;
        rec.since = dir_table[i].e_since;
        rec.last = 1'b1;
        table_exp.push_back(rec);
      end
      send_word(dir_table[i].c, dir_table[i].typed);
    end

    for (int ph = 0; ph < 5; ph++) begin
      set_wrap(wrap_plan[ph]);
      base = words_sent;
      while (words_sent - base < PHASE_WORDS) random_item();
    end

    start = 1'b0;
    while (actions_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
